FILE: hw/rtl/tdt_pkg.sv
// Package for the tap and double-tap recognizer: codes, widths, defaults and shared types.
`default_nettype none
package tdt_pkg;

  // Default geometry of the pointer data
  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Configuration register widths and reset values
  localparam int SLOP_W   = 10;
  localparam int WIN_W    = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [SLOP_W-1:0] SLOP_RST = SLOP_W'(18);
  localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(300000);
  localparam logic              EN_RST   = 1'b1;
  localparam int SLOP_MAX = (1 << SLOP_W) - 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOP   = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_ENABLE = 2'd2
  } cfg_idx_e;

  // Pointer commands
  typedef enum logic [2:0] {
    CMD_DOWN   = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_UP     = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_e;

  // Button codes
  localparam logic [1:0] BTN_LEFT  = 2'd0;
  localparam logic [1:0] BTN_RIGHT = 2'd1;

  // Gesture event codes
  typedef enum logic [3:0] {
    EVT_TAP_DOWN       = 4'd0,
    EVT_SECONDARY_DOWN = 4'd1,
    EVT_DOUBLE_DOWN    = 4'd2,
    EVT_TAP_UP         = 4'd3,
    EVT_TAP            = 4'd4,
    EVT_SECONDARY_UP   = 4'd5,
    EVT_SECONDARY_TAP  = 4'd6,
    EVT_DOUBLE_TAP     = 4'd7,
    EVT_TAP_CANCEL     = 4'd8,
    EVT_DOUBLE_CANCEL  = 4'd9
  } evt_e;

  // Live configuration handed to the core
  typedef struct packed {
    logic [SLOP_W-1:0] slop;
    logic [WIN_W-1:0]  window;
    logic              enabled;
  } cfg_t;

  // Results of one item: count (0..2) and up to two event codes
  typedef struct packed {
    logic [1:0] count;
    evt_e       first;
    evt_e       second;
  } res_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tdt_if.sv
// Valid/ready channel interfaces for pointer items and gesture results.
`default_nettype none
interface tdt_in_if #(
  parameter int COORD_BITS = 16,
  parameter int TIME_BITS  = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   command;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [1:0]                   button;
  logic [TIME_BITS-1:0]         stamp;

  modport source (output valid, command, pos_x, pos_y, button, stamp, input ready);
  modport sink   (input valid, command, pos_x, pos_y, button, stamp, output ready);
endinterface

interface tdt_out_if #(
  parameter int COORD_BITS = 16,
  parameter int TIME_BITS  = 32
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   event_code;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic [1:0]                   out_button;
  logic [TIME_BITS-1:0]         out_time;
  logic                         last_of_run;

  modport source (output valid, event_code, out_x, out_y, out_button, out_time,
                  last_of_run, input ready);
  modport sink   (input valid, event_code, out_x, out_y, out_button, out_time,
                  last_of_run, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tap_double_tap_recognizer_top.sv
// Top level of the tap and double-tap recognizer.
// Pointer items enter an input register; the gesture decision and state update
// happen in one pass from there into a result register that holds both events
// of an item. Items with zero or one result stream at one per cycle while the
// receiver is ready; an item with two results holds the result register until
// both events drain, because the single result port drains one event per
// transfer. The first result is valid once the item has passed through the
// input register and been loaded into the result register.
// Configuration writes take effect at the next edge.
`default_nettype none
module tap_double_tap_recognizer_top
  import tdt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tdt_in_if.sink                    in_ch,
  tdt_out_if.source                 out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  logic                         in_valid_q;
  logic [2:0]                   cmd_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [1:0]                   btn_q;
  logic [TIME_BITS-1:0]         stamp_q;
  logic                         go, can_load;
  cfg_t                         cfg_q;
  res_ctl_t                     ctl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slop    <= SLOP_RST;
      cfg_q.window  <= WIN_RST;
      cfg_q.enabled <= EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLOP:   cfg_q.slop    <= cfg_wdata_i[SLOP_W-1:0];
        CFG_WINDOW: cfg_q.window  <= cfg_wdata_i[WIN_W-1:0];
        CFG_ENABLE: cfg_q.enabled <= cfg_wdata_i[0];
        default:    cfg_q         <= cfg_q;
      endcase
    end
  end

  // Input register
  assign go          = in_valid_q && can_load;
  assign in_ch.ready = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_q   <= in_ch.command;
      x_q     <= in_ch.pos_x;
      y_q     <= in_ch.pos_y;
      btn_q   <= in_ch.button;
      stamp_q <= in_ch.stamp;
    end
  end

  tdt_core #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .cmd_i   (cmd_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .btn_i   (btn_q),
    .stamp_i (stamp_q),
    .cfg_i   (cfg_q),
    .ctl_o   (ctl)
  );

  tdt_out_buf #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (go),
    .ctl_i      (ctl),
    .x_i        (x_q),
    .y_i        (y_q),
    .btn_i      (btn_q),
    .time_i     (stamp_q),
    .can_load_o (can_load),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tdt_slop_chk.sv
// Squared-distance test of two points against the squared slop radius.
`default_nettype none
module tdt_slop_chk
  import tdt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic signed [COORD_BITS-1:0] ax_i,
  input  wire logic signed [COORD_BITS-1:0] ay_i,
  input  wire logic signed [COORD_BITS-1:0] bx_i,
  input  wire logic signed [COORD_BITS-1:0] by_i,
  input  wire logic [SLOP_W-1:0]            slop_i,
  output      logic                         near_o
);

  localparam int MW = (COORD_BITS > SLOP_W) ? COORD_BITS : SLOP_W;

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS-1:0]      mag_x, mag_y;
  logic [MW-1:0]              ext_x, ext_y;
  logic                       fit_x, fit_y;
  logic [2*SLOP_W-1:0]        sq_x, sq_y, sq_r;
  logic [2*SLOP_W:0]          sum;

  // Absolute coordinate gaps
  assign diff_x = $signed({ax_i[COORD_BITS-1], ax_i}) - $signed({bx_i[COORD_BITS-1], bx_i});
  assign diff_y = $signed({ay_i[COORD_BITS-1], ay_i}) - $signed({by_i[COORD_BITS-1], by_i});
  assign mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
  assign ext_x  = MW'(mag_x);
  assign ext_y  = MW'(mag_y);

  // A gap beyond the largest radius is out of slop whatever the radius
  assign fit_x = (ext_x <= MW'(SLOP_MAX));
  assign fit_y = (ext_y <= MW'(SLOP_MAX));

  // Squares on the narrow gap only
  assign sq_x = ext_x[SLOP_W-1:0] * ext_x[SLOP_W-1:0];
  assign sq_y = ext_y[SLOP_W-1:0] * ext_y[SLOP_W-1:0];
  assign sq_r = slop_i * slop_i;
  assign sum  = {1'b0, sq_x} + {1'b0, sq_y};

  assign near_o = fit_x && fit_y && (sum <= {1'b0, sq_r});

endmodule
`default_nettype wire

FILE: hw/rtl/tdt_core.sv
// Gesture state and per-item decision logic of the tap recognizer.
`default_nettype none
module tdt_core
  import tdt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire logic [2:0]                   cmd_i,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  input  wire logic [1:0]                   btn_i,
  input  wire logic [TIME_BITS-1:0]         stamp_i,
  input  wire cfg_t                         cfg_i,
  output      res_ctl_t                     ctl_o
);

  localparam int EW = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  logic                         pressed_q, pressed_d;
  logic signed [COORD_BITS-1:0] press_x_q, press_x_d, press_y_q, press_y_d;
  logic [1:0]                   press_btn_q, press_btn_d;
  logic [TIME_BITS-1:0]         press_time_q, press_time_d;
  logic                         pending_q, pending_d;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [TIME_BITS-1:0]         prev_time_q, prev_time_d;

  logic                 near_press, near_prev, in_window, dbl_ok;
  logic [TIME_BITS-1:0] elapsed;

  // Distance to the held press and to the remembered tap
  tdt_slop_chk #(.COORD_BITS(COORD_BITS)) u_chk_press (
    .ax_i(x_i), .ay_i(y_i), .bx_i(press_x_q), .by_i(press_y_q),
    .slop_i(cfg_i.slop), .near_o(near_press)
  );

  tdt_slop_chk #(.COORD_BITS(COORD_BITS)) u_chk_prev (
    .ax_i(x_i), .ay_i(y_i), .bx_i(prev_x_q), .by_i(prev_y_q),
    .slop_i(cfg_i.slop), .near_o(near_prev)
  );

  // Double-tap window, elapsed time wraps with the stamp counter
  assign elapsed   = stamp_i - prev_time_q;
  assign in_window = (EW'(elapsed) <= EW'(cfg_i.window));
  assign dbl_ok    = cfg_i.enabled && pending_q && in_window && near_prev;

  // Decision and next state
  always_comb begin
    pressed_d    = pressed_q;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    press_btn_d  = press_btn_q;
    press_time_d = press_time_q;
    pending_d    = pending_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    prev_time_d  = prev_time_q;
    ctl_o.count  = 2'd0;
    ctl_o.first  = EVT_TAP_DOWN;
    ctl_o.second = EVT_TAP_DOWN;
    if (go_i) begin
      case (cmd_i)
        CMD_DOWN: begin
          pressed_d    = 1'b1;
          press_x_d    = x_i;
          press_y_d    = y_i;
          press_btn_d  = btn_i;
          press_time_d = stamp_i;
          if (dbl_ok) begin
            ctl_o.count = 2'd1;
            ctl_o.first = EVT_DOUBLE_DOWN;
          end else if (btn_i == BTN_RIGHT) begin
            ctl_o.count = 2'd1;
            ctl_o.first = EVT_SECONDARY_DOWN;
          end else if (btn_i == BTN_LEFT) begin
            ctl_o.count = 2'd1;
            ctl_o.first = EVT_TAP_DOWN;
          end
        end
        CMD_MOVE: begin
          if (pressed_q && !near_press) begin
            pressed_d    = 1'b0;
            pending_d    = 1'b0;
            ctl_o.count  = 2'd2;
            ctl_o.first  = EVT_TAP_CANCEL;
            ctl_o.second = EVT_DOUBLE_CANCEL;
          end
        end
        CMD_UP: begin
          if (pressed_q) begin
            pressed_d = 1'b0;
            if (near_press) begin
              if (press_btn_q == BTN_RIGHT) begin
                pending_d    = 1'b0;
                ctl_o.count  = 2'd2;
                ctl_o.first  = EVT_SECONDARY_UP;
                ctl_o.second = EVT_SECONDARY_TAP;
              end else if (press_btn_q == BTN_LEFT) begin
                if (dbl_ok) begin
                  pending_d   = 1'b0;
                  ctl_o.count = 2'd1;
                  ctl_o.first = EVT_DOUBLE_TAP;
                end else begin
                  // remember this tap only when double-tap is on
                  pending_d = cfg_i.enabled;
                  if (cfg_i.enabled) begin
                    prev_x_d    = x_i;
                    prev_y_d    = y_i;
                    prev_time_d = stamp_i;
                  end
                  ctl_o.count  = 2'd2;
                  ctl_o.first  = EVT_TAP_UP;
                  ctl_o.second = EVT_TAP;
                end
              end
            end else begin
              pending_d   = 1'b0;
              ctl_o.count = 2'd1;
              ctl_o.first = EVT_TAP_CANCEL;
            end
          end
        end
        CMD_CANCEL: begin
          if (pressed_q) begin
            pressed_d    = 1'b0;
            pending_d    = 1'b0;
            ctl_o.count  = 2'd2;
            ctl_o.first  = EVT_TAP_CANCEL;
            ctl_o.second = EVT_DOUBLE_CANCEL;
          end
        end
        CMD_RESET: begin
          pressed_d = 1'b0;
          pending_d = 1'b0;
        end
        default: begin
          pressed_d = pressed_q;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      press_btn_q  <= '0;
      press_time_q <= '0;
      pending_q    <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_time_q  <= '0;
    end else begin
      pressed_q    <= pressed_d;
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      press_btn_q  <= press_btn_d;
      press_time_q <= press_time_d;
      pending_q    <= pending_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      prev_time_q  <= prev_time_d;
    end
  end

  // A tap becomes pending only through a release
  a_pending_from_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(go_i && (cmd_i == CMD_UP) && cfg_i.enabled))
    else $error("tap pending without a release");

  // Reset command clears the gesture
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && (cmd_i == CMD_RESET)) |=> (!pressed_q && !pending_q))
    else $error("reset command left gesture state");

endmodule
`default_nettype wire

FILE: hw/rtl/tdt_out_buf.sv
// Result register: holds up to two events of one item and sends them in order.
`default_nettype none
module tdt_out_buf
  import tdt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire res_ctl_t                     ctl_i,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  input  wire logic [1:0]                   btn_i,
  input  wire logic [TIME_BITS-1:0]         time_i,
  output      logic                         can_load_o,
  tdt_out_if.source                         out_ch
);

  logic [1:0]                   cnt_q, cnt_d;
  evt_e                         first_q, second_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [1:0]                   btn_q;
  logic [TIME_BITS-1:0]         time_q;
  logic                         fire;

  assign fire       = out_ch.valid && out_ch.ready;
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && fire);

  // Remaining-result count
  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = ctl_i.count;
    end else if (fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload; a single result sits in the second slot
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_q  <= ctl_i.first;
      second_q <= (ctl_i.count == 2'd2) ? ctl_i.second : ctl_i.first;
      x_q      <= x_i;
      y_q      <= y_i;
      btn_q    <= btn_i;
      time_q   <= time_i;
    end
  end

  // Output channel
  assign out_ch.valid       = (cnt_q != 2'd0);
  assign out_ch.event_code  = (cnt_q == 2'd2) ? first_q : second_q;
  assign out_ch.out_x       = x_q;
  assign out_ch.out_y       = y_q;
  assign out_ch.out_button  = btn_q;
  assign out_ch.out_time    = time_q;
  assign out_ch.last_of_run = (cnt_q == 2'd1);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && fire)))
    else $error("result register loaded while busy");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the tap and double-tap recognizer top level.
module tb_top;
  import tdt_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int TW = TIME_BITS_DEF;
  localparam int SIM_LIMIT = 20_000_000;

  // Buttons with no gesture of their own
  localparam logic [1:0] BTN_OTHER = 2'd2;
  localparam logic [1:0] BTN_SPARE = 2'd3;

  typedef struct {
    logic [2:0]           command;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [1:0]           button;
    logic [TW-1:0]        stamp;
  } pointer_item_t;

  typedef struct {
    evt_e                 code;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [1:0]           button;
    logic [TW-1:0]        stamp;
    logic                 last;
  } gesture_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  tdt_in_if #(.COORD_BITS(CW), .TIME_BITS(TW)) in_ch ();
  tdt_out_if #(.COORD_BITS(CW), .TIME_BITS(TW)) out_ch ();

  tap_double_tap_recognizer_top #(.COORD_BITS(CW), .TIME_BITS(TW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Gesture state tracked alongside the block
  logic [SLOP_W-1:0] slop_r;
  logic [WIN_W-1:0] dbl_window;
  logic dbl_enable;
  logic held;
  logic signed [CW-1:0] held_x, held_y;
  logic [1:0] held_btn;
  logic tap_armed;
  logic signed [CW-1:0] armed_x, armed_y;
  logic [TW-1:0] armed_stamp;

  gesture_t gesture_q[$];
  int failures = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  int hold_request = 0;
  logic [TW-1:0] clock_now;

  // True when two points lie within the slop circle (exact squared distance)
  function automatic bit near(input logic signed [CW-1:0] ax, ay, bx, by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx * dx + dy * dy) <= longint'(slop_r) * longint'(slop_r);
  endfunction

  // Second press or release still counts toward a double tap
  function automatic bit second_tap_ok(input logic [TW-1:0] now,
                                       input logic signed [CW-1:0] x, y);
    logic [TW-1:0] elapsed;
    elapsed = now - armed_stamp;
    return dbl_enable && tap_armed && (elapsed <= TW'(dbl_window)) &&
           near(x, y, armed_x, armed_y);
  endfunction

  // Work out the events one pointer item causes and queue them
  task automatic recognize_gesture(input pointer_item_t it);
    evt_e codes[$];
    gesture_t g;
    case (it.command)
      CMD_DOWN: begin
        held = 1'b1;
        held_x = it.x;
        held_y = it.y;
        held_btn = it.button;
        if (second_tap_ok(it.stamp, it.x, it.y)) codes.push_back(EVT_DOUBLE_DOWN);
        else if (it.button == BTN_RIGHT) codes.push_back(EVT_SECONDARY_DOWN);
        else if (it.button == BTN_LEFT) codes.push_back(EVT_TAP_DOWN);
      end
      CMD_MOVE, CMD_CANCEL: begin
        if (held && (it.command == CMD_CANCEL || !near(it.x, it.y, held_x, held_y))) begin
          held = 1'b0;
          tap_armed = 1'b0;
          codes.push_back(EVT_TAP_CANCEL);
          codes.push_back(EVT_DOUBLE_CANCEL);
        end
      end
      CMD_UP: begin
        if (held) begin
          held = 1'b0;
          if (!near(it.x, it.y, held_x, held_y)) begin
            tap_armed = 1'b0;
            codes.push_back(EVT_TAP_CANCEL);
          end else if (held_btn == BTN_RIGHT) begin
            tap_armed = 1'b0;
            codes.push_back(EVT_SECONDARY_UP);
            codes.push_back(EVT_SECONDARY_TAP);
          end else if (held_btn == BTN_LEFT) begin
            if (second_tap_ok(it.stamp, it.x, it.y)) begin
              tap_armed = 1'b0;
              codes.push_back(EVT_DOUBLE_TAP);
            end else begin
              // remember this tap only when double taps are wanted
              tap_armed = dbl_enable;
              if (dbl_enable) begin
                armed_x = it.x;
                armed_y = it.y;
                armed_stamp = it.stamp;
              end
              codes.push_back(EVT_TAP_UP);
              codes.push_back(EVT_TAP);
            end
          end
        end
      end
      CMD_RESET: begin
        held = 1'b0;
        tap_armed = 1'b0;
      end
      default: ;
    endcase
    foreach (codes[i]) begin
      g = '{codes[i], it.x, it.y, it.button, it.stamp, i == codes.size() - 1};
      gesture_q.push_back(g);
    end
  endtask

  task automatic compare_field(input string name, input logic [TW-1:0] want,
                               input logic [TW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  // Compare one result transfer with the oldest queued event
  task automatic check_event();
    gesture_t want;
    if (gesture_q.size() == 0) begin
      $display("%0t: unexpected event, expected none, actual code %0d", $time,
               out_ch.event_code);
      failures++;
    end else begin
      want = gesture_q.pop_front();
      compare_field("event_code", TW'(want.code), TW'(out_ch.event_code));
      compare_field("out_x", TW'(want.x), TW'(out_ch.out_x));
      compare_field("out_y", TW'(want.y), TW'(out_ch.out_y));
      compare_field("out_button", TW'(want.button), TW'(out_ch.out_button));
      compare_field("out_time", want.stamp, out_ch.out_time);
      compare_field("last_of_run", TW'(want.last), TW'(out_ch.last_of_run));
    end
  endtask

  // Result side: random stalls, long hold on request, check every transfer
  initial begin : event_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) check_event();
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && hold_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one pointer item and predict its events on transfer
  task automatic send_item(input logic [2:0] cmd, input logic signed [CW-1:0] x, y,
                           input logic [1:0] btn, input logic [TW-1:0] stamp);
    pointer_item_t it;
    it = '{cmd, x, y, btn, stamp};
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.button <= btn;
    in_ch.stamp <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    recognize_gesture(it);
  endtask

  // Stop offering, let all events drain and the pipeline settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SLOP:   slop_r = data[SLOP_W-1:0];
      CFG_WINDOW: dbl_window = data[WIN_W-1:0];
      CFG_ENABLE: dbl_enable = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] slop_word, window_word, enable_word);
    quiesce();
    write_cfg(CFG_SLOP, slop_word);
    write_cfg(CFG_WINDOW, window_word);
    write_cfg(CFG_ENABLE, enable_word);
  endtask

  // Offset near the slop edge, inside it most of the time
  function automatic logic signed [CW-1:0] jitter();
    int r;
    r = int'(slop_r);
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return CW'(r);
      3: return CW'(-r);
      4: return CW'(r + 1);
      default: return CW'(int'($urandom_range(0, 2 * r)) - r);
    endcase
  endfunction

  // Tick advance: zero, window boundaries, far jumps or well inside
  function automatic logic [TW-1:0] time_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TW'(dbl_window);
      2: return TW'(dbl_window) + 1'b1;
      3: return TW'($urandom);
      default: return TW'($urandom_range(0, int'(dbl_window) / 4));
    endcase
  endfunction

  function automatic logic [1:0] pick_button();
    case ($urandom_range(0, 9))
      0, 1: return BTN_RIGHT;
      2: return BTN_OTHER;
      3: return BTN_SPARE;
      default: return BTN_LEFT;
    endcase
  endfunction

  // Press, wander a little, release
  task automatic press_release(input logic signed [CW-1:0] x, y, input logic [1:0] btn);
    clock_now += time_step();
    send_item(CMD_DOWN, x, y, btn, clock_now);
    repeat ($urandom_range(0, 2)) begin
      clock_now += time_step() >> 3;
      send_item(CMD_MOVE, x + jitter(), y + jitter(), pick_button(), clock_now);
    end
    clock_now += time_step();
    send_item(CMD_UP, x + jitter(), y + jitter(), pick_button(), clock_now);
  endtask

  // Mostly well-formed gestures with random content, some noise
  task automatic random_gestures(input int n_items);
    logic signed [CW-1:0] bx, by;
    int start;
    int kind;
    start = items_sent;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(0, 9);
      bx = CW'($urandom);
      by = CW'($urandom);
      if (kind <= 4) begin
        press_release(bx, by, pick_button());
        if (kind >= 2) press_release(bx + jitter(), by + jitter(), pick_button());
      end else if (kind <= 6) begin
        clock_now += time_step();
        send_item(CMD_DOWN, bx, by, pick_button(), clock_now);
        clock_now += time_step();
        if (kind == 5) send_item(CMD_CANCEL, bx, by, pick_button(), clock_now);
        else send_item(CMD_MOVE, bx + CW'(slop_r) + CW'($urandom_range(1, 40)), by,
                       pick_button(), clock_now);
      end else if (kind == 7) begin
        send_item(CMD_RESET, bx, by, pick_button(), $urandom);
      end else begin
        send_item(3'($urandom_range(0, 7)), bx, by, 2'($urandom), $urandom);
      end
    end
  endtask

  // Hand-picked sequences at reset settings
  task automatic test_directed();
    send_item(CMD_DOWN, 0, 0, BTN_LEFT, 100);
    send_item(CMD_UP, 3, 4, BTN_LEFT, 200);
    send_item(CMD_DOWN, 5, 5, BTN_LEFT, 300);
    send_item(CMD_UP, 5, 5, BTN_LEFT, 400);
    // secondary tap released exactly on the slop edge
    send_item(CMD_DOWN, 100, 100, BTN_RIGHT, 500);
    send_item(CMD_UP, 100, 118, BTN_RIGHT, 600);
    // other-button press keeps the pending tap alive
    send_item(CMD_DOWN, 0, 0, BTN_LEFT, 700);
    send_item(CMD_UP, 0, 0, BTN_LEFT, 800);
    send_item(CMD_DOWN, 1000, 1000, BTN_OTHER, 900);
    send_item(CMD_UP, 1000, 1000, BTN_OTHER, 1000);
    send_item(CMD_DOWN, 0, 0, BTN_LEFT, 1100);
    send_item(CMD_MOVE, 19, 0, BTN_LEFT, 1200);
    // move, release and cancel with nothing pressed
    send_item(CMD_MOVE, 50, 50, BTN_LEFT, 1300);
    send_item(CMD_UP, 50, 50, BTN_LEFT, 1400);
    send_item(CMD_CANCEL, 50, 50, BTN_LEFT, 1500);
    // coordinate extremes, re-press while held, spare button
    send_item(CMD_DOWN, -32768, -32768, BTN_LEFT, 32'hFFFF_FF00);
    send_item(CMD_DOWN, 32767, 32767, BTN_SPARE, 32'hFFFF_FFE0);
    send_item(CMD_UP, 32767, 32767, BTN_SPARE, 32'hFFFF_FFE8);
    // double-tap press across the time wrap, then cancel
    send_item(CMD_DOWN, 32767, 32767, BTN_LEFT, 32'hFFFF_FFF0);
    send_item(CMD_UP, 32767, 32767, BTN_LEFT, 32'hFFFF_FFF8);
    send_item(CMD_DOWN, 32767, 32767, BTN_LEFT, 32'h0000_0010);
    send_item(CMD_CANCEL, 32767, 32767, BTN_LEFT, 32'h0000_0020);
    // zero stamp, then reset command drops the pending tap
    send_item(CMD_DOWN, 0, 0, BTN_LEFT, 0);
    send_item(CMD_UP, 0, -18, BTN_LEFT, 0);
    send_item(CMD_RESET, 0, 0, BTN_LEFT, 0);
    send_item(CMD_DOWN, 0, -18, BTN_LEFT, 0);
    send_item(CMD_UP, -32768, 32767, BTN_LEFT, 5);
    // unused command codes
    for (int c = int'(CMD_RESET) + 1; c < 8; c++)
      send_item(3'(c), 1, 1, BTN_LEFT, 6);
  endtask

  // Extremes and random settings of all three registers
  task automatic test_config_sweep();
    apply_config('0, '0, CFG_W'(1));
    random_gestures(150);
    apply_config(CFG_W'(SLOP_MAX), {CFG_W{1'b1}}, CFG_W'(1));
    random_gestures(150);
    apply_config(CFG_W'(SLOP_RST), CFG_W'(WIN_RST), '0);
    random_gestures(150);
    repeat (2) begin
      apply_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      random_gestures(100);
    end
  endtask

  // Receiver holds off while taps keep coming, so the input stalls
  task automatic test_backpressure();
    apply_config(CFG_W'(SLOP_RST), CFG_W'(WIN_RST), CFG_W'(EN_RST));
    idle_on = 1'b0;
    hold_request = 200;
    repeat (30) begin
      clock_now += TW'(dbl_window) + 1'b1;
      send_item(CMD_DOWN, 7, -7, BTN_LEFT, clock_now);
      send_item(CMD_UP, 7, -7, BTN_LEFT, clock_now);
    end
    idle_on = 1'b1;
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_streaming();
    apply_config(CFG_W'(SLOP_RST), CFG_W'(WIN_RST), CFG_W'(EN_RST));
    idle_on = 1'b0;
    random_gestures(700);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.button = '0;
    in_ch.stamp = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    slop_r = SLOP_RST;
    dbl_window = WIN_RST;
    dbl_enable = EN_RST;
    held = 1'b0;
    held_x = '0;
    held_y = '0;
    held_btn = '0;
    tap_armed = 1'b0;
    armed_x = '0;
    armed_y = '0;
    armed_stamp = '0;
    clock_now = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_streaming();
    quiesce();
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(SIM_LIMIT);
    $display("%0t: timeout, %0d events still queued", $time, gesture_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
